// ===== design/one_wire_bus_master_defines.svh =====
// assertion macros for the one-wire bus master
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on i_clk, off during reset
`define OWBM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("one_wire_bus_master: assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define OWBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("one_wire_bus_master: assertion failed");

`else

`define OWBM_ASSERT_IMP(label, ante, cons)
`define OWBM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/owbm_pkg.sv =====
package owbm_pkg;

    localparam int US_W        = 10;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        KIND_IDLE  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    // slot timing in microseconds, counted from the start of the slot
    localparam logic [US_W-1:0] RST_LOW_US    = 10'd480;
    localparam logic [US_W-1:0] RST_SAMPLE_US = 10'd550;
    localparam logic [US_W-1:0] RST_END_US    = 10'd960;
    localparam logic [US_W-1:0] W1_LOW_US     = 10'd5;
    localparam logic [US_W-1:0] W1_END_US     = 10'd60;
    localparam logic [US_W-1:0] W0_LOW_US     = 10'd60;
    localparam logic [US_W-1:0] W0_END_US     = 10'd65;
    localparam logic [US_W-1:0] RD_LOW_US     = 10'd2;
    localparam logic [US_W-1:0] RD_SAMPLE_US  = 10'd12;
    localparam logic [US_W-1:0] RD_END_US     = 10'd62;
    localparam logic [2:0]      LAST_BIT      = 3'd7;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_to_send;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic       line_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] received_byte;
        logic       rejected;
    } t_result;

    function automatic logic [OUT_TDATA_W-1:0] pack_result(input t_result r);
        logic [OUT_TDATA_W-1:0] d;
        d        = '0;
        d[0]     = r.line_low;
        d[1]     = r.busy_res;
        d[2]     = r.done_res;
        d[3]     = r.presence;
        d[11:4]  = r.received_byte;
        d[12]    = r.rejected;
        return d;
    endfunction

endpackage

// ===== design/owbm_in_reg.sv =====
module owbm_in_reg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic                                i_adv,
    input  logic [1:0]                          i_op,
    input  logic [owbm_pkg::IN_TDATA_W-1:0]     i_data,
    output logic                                o_valid,
    output owbm_pkg::t_item                     o_item
);

    logic            r_valid;
    owbm_pkg::t_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item.op           <= i_op;
            r_item.byte_to_send <= i_data[7:0];
            r_item.line_level   <= i_data[8];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== design/owbm_engine.sv =====
module owbm_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_fire,
    input  owbm_pkg::t_item     i_item,
    output owbm_pkg::t_result   o_result
);

    owbm_pkg::t_kind             r_kind, n_kind;
    logic [owbm_pkg::US_W-1:0]   r_us, n_us;
    logic [7:0]                  r_pre, n_pre;
    logic [2:0]                  r_bit, n_bit;
    logic [7:0]                  r_shift, n_shift;
    logic                        r_pres, n_pres;
    logic                        r_drive, n_drive;
    logic [7:0]                  r_last, n_last;
    logic [7:0]                  r_tpu;

    owbm_pkg::t_kind             w_op;
    logic [owbm_pkg::US_W-1:0]   w_t;
    logic [8:0]                  w_pre_inc;
    logic                        w_bit;
    logic                        w_slot_end;
    logic                        w_done;
    logic                        w_rej;

    assign w_op      = owbm_pkg::t_kind'(i_item.op);
    assign w_t       = r_us + 10'd1;
    assign w_pre_inc = {1'b0, r_pre} + 9'd1;
    assign w_bit     = r_shift[r_bit];

    always_comb begin
        n_kind     = r_kind;
        n_us       = r_us;
        n_pre      = r_pre;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_pres     = r_pres;
        n_drive    = r_drive;
        n_last     = r_last;
        w_slot_end = 1'b0;
        w_done     = 1'b0;
        w_rej      = 1'b0;
        if (w_op != owbm_pkg::KIND_IDLE) begin
            if (r_kind != owbm_pkg::KIND_IDLE) begin
                w_rej = 1'b1;
            end else begin
                n_kind  = w_op;
                n_us    = '0;
                n_pre   = '0;
                n_bit   = '0;
                n_shift = (w_op == owbm_pkg::KIND_WRITE) ? i_item.byte_to_send : 8'd0;
                n_drive = 1'b1;
            end
        end else if (r_kind != owbm_pkg::KIND_IDLE) begin
            // a zero divisor behaves as one: the compare always passes
            if (w_pre_inc >= {1'b0, r_tpu}) begin
                n_pre = '0;
                n_us  = w_t;
                unique case (r_kind)
                    owbm_pkg::KIND_RESET: begin
                        if (w_t >= owbm_pkg::RST_LOW_US) n_drive = 1'b0;
                        if (w_t == owbm_pkg::RST_SAMPLE_US) n_pres = ~i_item.line_level;
                        if (w_t >= owbm_pkg::RST_END_US) begin
                            n_kind  = owbm_pkg::KIND_IDLE;
                            n_drive = 1'b0;
                            w_done  = 1'b1;
                        end
                    end
                    owbm_pkg::KIND_WRITE: begin
                        if (w_t >= (w_bit ? owbm_pkg::W1_LOW_US : owbm_pkg::W0_LOW_US)) begin
                            n_drive = 1'b0;
                        end
                        if (w_t >= (w_bit ? owbm_pkg::W1_END_US : owbm_pkg::W0_END_US)) begin
                            w_slot_end = 1'b1;
                        end
                    end
                    owbm_pkg::KIND_READ: begin
                        if (w_t >= owbm_pkg::RD_LOW_US) n_drive = 1'b0;
                        if (w_t == owbm_pkg::RD_SAMPLE_US && i_item.line_level) begin
                            n_shift[r_bit] = 1'b1;
                        end
                        if (w_t >= owbm_pkg::RD_END_US) begin
                            if (r_bit == owbm_pkg::LAST_BIT) n_last = n_shift;
                            w_slot_end = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (w_slot_end) begin
                    if (r_bit == owbm_pkg::LAST_BIT) begin
                        n_kind  = owbm_pkg::KIND_IDLE;
                        n_drive = 1'b0;
                        w_done  = 1'b1;
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_us    = '0;
                        n_drive = 1'b1;
                    end
                end
            end else begin
                n_pre = w_pre_inc[7:0];
            end
        end
        if (n_kind == owbm_pkg::KIND_IDLE) n_pre = '0;
    end

    always_comb begin
        o_result.line_low      = n_drive;
        o_result.busy_res      = (n_kind != owbm_pkg::KIND_IDLE);
        o_result.done_res      = w_done;
        o_result.presence      = n_pres;
        o_result.received_byte = n_last;
        o_result.rejected      = w_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu <= 8'd1;
        end else if (i_cfg_we) begin
            r_tpu <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= owbm_pkg::KIND_IDLE;
            r_us    <= '0;
            r_pre   <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_pres  <= 1'b0;
            r_drive <= 1'b0;
            r_last  <= '0;
        end else if (i_fire) begin
            r_kind  <= n_kind;
            r_us    <= n_us;
            r_pre   <= n_pre;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_pres  <= n_pres;
            r_drive <= n_drive;
            r_last  <= n_last;
        end
    end

endmodule

// ===== design/owbm_out_reg.sv =====
module owbm_out_reg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  owbm_pkg::t_result                   i_result,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic [owbm_pkg::OUT_TDATA_W-1:0]    o_data
);

    logic                             r_valid;
    logic [owbm_pkg::OUT_TDATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= owbm_pkg::pack_result(i_result);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/one_wire_bus_master.sv =====
// One-wire bus master timing engine. Each input word is a tick (carrying the
// sampled line level) or a command: bus reset, write byte or read byte, bits
// LSB first. Ticks are divided by ticks_per_us into microseconds that step the
// slot timing; every word yields exactly one result word with the line drive,
// busy, done, presence, last read byte and a rejected flag for a command that
// arrives while busy. A word passes an input register, the step logic and an
// output register, and one word is accepted every cycle as long as the result
// side keeps taking words.
// The configuration port is always ready; write it only while idle.
`include "one_wire_bus_master_defines.svh"

module one_wire_bus_master (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [7:0]                          i_cfg_data,   // ticks_per_us
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [owbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata, // byte_to_send, line_level
    input  logic [1:0]                          s_axis_tuser, // op
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // line_low, busy_res, done_res, presence, received_byte, rejected
    output logic [owbm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic              w_in_valid;
    owbm_pkg::t_item   w_item;
    owbm_pkg::t_result w_result;
    logic              w_fire;
    logic              w_load;

    assign o_cfg_ready   = 1'b1;
    assign w_fire        = w_in_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !w_in_valid || w_fire;
    assign w_load        = s_axis_tvalid && s_axis_tready;

    owbm_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_adv   (w_fire),
        .i_op    (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    owbm_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_fire     (w_fire),
        .i_item     (w_item),
        .o_result   (w_result)
    );

    owbm_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_data   (m_axis_tdata)
    );

    // a finishing word always leaves the line released and the engine idle
    `OWBM_ASSERT_IMP(a_done_idle, w_fire && w_result.done_res, !w_result.busy_res && !w_result.line_low)
    // a command is only refused while an operation runs
    `OWBM_ASSERT_IMP(a_rej_busy, w_fire && w_result.rejected, w_result.busy_res)
    // the line is never pulled low while idle
    `OWBM_ASSERT_IMP(a_low_busy, w_fire && w_result.line_low, w_result.busy_res)
    // every processed word shows up at the output in the following cycle
    `OWBM_ASSERT_NEXT(a_fire_out, w_fire, m_axis_tvalid)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

typedef enum int {LVL_LOW, LVL_HIGH, LVL_RAND} t_level_mode;

// tracks the bus engine state and holds the result words still to come
class bus_word_scoreboard;
    logic [7:0]                     tpu;
    owbm_pkg::t_kind                kind;
    logic [owbm_pkg::US_W-1:0]      us_cnt;
    logic [7:0]                     pre_cnt;
    logic [2:0]                     bit_pos;
    logic [7:0]                     shreg;
    logic                           presence_q;
    logic                           drive_q;
    logic [7:0]                     last_read;
    owbm_pkg::t_result              expected_words[$];
    int                             errors;
    int                             words_checked;
    int                             ops_done;
    int                             cmds_rejected;
    int                             cmds_started[4];

    function new();
        tpu        = 8'd1;
        kind       = owbm_pkg::KIND_IDLE;
        us_cnt     = '0;
        pre_cnt    = '0;
        bit_pos    = '0;
        shreg      = '0;
        presence_q = 1'b0;
        drive_q    = 1'b0;
        last_read  = '0;
        errors     = 0;
        words_checked = 0;
        ops_done   = 0;
        cmds_rejected = 0;
        foreach (cmds_started[i]) cmds_started[i] = 0;
    endfunction

    // closes a bit slot, returns 1 when the byte is complete
    function bit close_slot();
        if (bit_pos == owbm_pkg::LAST_BIT) begin
            kind    = owbm_pkg::KIND_IDLE;
            drive_q = 1'b0;
            return 1'b1;
        end
        bit_pos = bit_pos + 3'd1;
        us_cnt  = '0;
        drive_q = 1'b1;
        return 1'b0;
    endfunction

    function bit step_microsecond(logic level);
        logic                      hot_bit;
        logic [owbm_pkg::US_W-1:0] low_len;
        logic [owbm_pkg::US_W-1:0] slot_len;
        us_cnt = us_cnt + 10'd1;
        case (kind)
            owbm_pkg::KIND_RESET: begin
                if (us_cnt >= owbm_pkg::RST_LOW_US) drive_q = 1'b0;
                if (us_cnt == owbm_pkg::RST_SAMPLE_US) presence_q = ~level;
                if (us_cnt >= owbm_pkg::RST_END_US) begin
                    kind    = owbm_pkg::KIND_IDLE;
                    drive_q = 1'b0;
                    return 1'b1;
                end
            end
            owbm_pkg::KIND_WRITE: begin
                hot_bit  = shreg[bit_pos];
                low_len  = hot_bit ? owbm_pkg::W1_LOW_US : owbm_pkg::W0_LOW_US;
                slot_len = hot_bit ? owbm_pkg::W1_END_US : owbm_pkg::W0_END_US;
                if (us_cnt >= low_len) drive_q = 1'b0;
                if (us_cnt >= slot_len) return close_slot();
            end
            owbm_pkg::KIND_READ: begin
                if (us_cnt >= owbm_pkg::RD_LOW_US) drive_q = 1'b0;
                if (us_cnt == owbm_pkg::RD_SAMPLE_US && level) shreg[bit_pos] = 1'b1;
                if (us_cnt >= owbm_pkg::RD_END_US) begin
                    if (bit_pos == owbm_pkg::LAST_BIT) last_read = shreg;
                    return close_slot();
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function void take_word(owbm_pkg::t_item it);
        owbm_pkg::t_result r;
        logic              fin;
        logic              rej;
        fin = 1'b0;
        rej = 1'b0;
        if (it.op != owbm_pkg::KIND_IDLE) begin
            if (kind != owbm_pkg::KIND_IDLE) begin
                rej = 1'b1;
            end else begin
                kind    = owbm_pkg::t_kind'(it.op);
                us_cnt  = '0;
                pre_cnt = '0;
                bit_pos = '0;
                shreg   = (it.op == owbm_pkg::KIND_WRITE) ? it.byte_to_send : 8'd0;
                drive_q = 1'b1;
                cmds_started[it.op]++;
            end
        end else if (kind != owbm_pkg::KIND_IDLE) begin
            // zero ticks per microsecond behaves like one
            if ({1'b0, pre_cnt} + 9'd1 >= {1'b0, tpu}) begin
                pre_cnt = '0;
                fin = step_microsecond(it.line_level);
            end else begin
                pre_cnt = pre_cnt + 8'd1;
            end
        end
        if (kind == owbm_pkg::KIND_IDLE) pre_cnt = '0;
        r.line_low      = drive_q;
        r.busy_res      = (kind != owbm_pkg::KIND_IDLE);
        r.done_res      = fin;
        r.presence      = presence_q;
        r.received_byte = last_read;
        r.rejected      = rej;
        expected_words.push_back(r);
    endfunction

    function void cmp_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            errors++;
        end
    endfunction

    function void check_word(logic [owbm_pkg::OUT_TDATA_W-1:0] d);
        owbm_pkg::t_result want;
        if (expected_words.size() == 0) begin
            $display("%0t: result word %h with nothing expected, expected none, actual %h",
                     $time, d, d);
            errors++;
            return;
        end
        want = expected_words.pop_front();
        words_checked++;
        if (want.done_res) ops_done++;
        if (want.rejected) cmds_rejected++;
        cmp_field("line_low", 8'(want.line_low), 8'(d[0]));
        cmp_field("busy_res", 8'(want.busy_res), 8'(d[1]));
        cmp_field("done_res", 8'(want.done_res), 8'(d[2]));
        cmp_field("presence", 8'(want.presence), 8'(d[3]));
        cmp_field("received_byte", want.received_byte, d[11:4]);
        cmp_field("rejected", 8'(want.rejected), 8'(d[12]));
    endfunction
endclass

module tb_top;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [7:0]                          i_cfg_data = 8'd0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [owbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;   // byte_to_send, line_level
    logic [1:0]                          s_axis_tuser = '0;   // op
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // line_low, busy_res, done_res, presence, received_byte, rejected
    logic [owbm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;

    bus_word_scoreboard sb;
    bit                 quiet = 1'b0;
    int                 words_sent = 0;
    string              tpu_list = "";

    one_wire_bus_master uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #80ms;
        $display("FAIL");
        $finish;
    end

    // result side: random stalls, check every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end

    function automatic logic pick_level(t_level_mode mode);
        case (mode)
            LVL_LOW:  return 1'b0;
            LVL_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_word(input owbm_pkg::t_kind op, input logic [7:0] byte_v,
                             input logic level);
        owbm_pkg::t_item it;
        it.op           = op;
        it.byte_to_send = byte_v;
        it.line_level   = level;
        if (!quiet) begin
            while ($urandom_range(0, 99) < 34) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, level, byte_v};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_word(it);
        words_sent++;
    endtask

    // stop sending until every result word is back
    task automatic hold_off();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_tpu(input logic [7:0] v);
        hold_off();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.tpu = v;
        tpu_list = {tpu_list, $sformatf(" %0d", v)};
    endtask

    // ticks until the engine is idle, with stray commands now and then (per mille)
    task automatic finish_op(input t_level_mode mode, input int noise);
        while (sb.kind != owbm_pkg::KIND_IDLE) begin
            if ($urandom_range(0, 999) < noise)
                send_word(owbm_pkg::t_kind'($urandom_range(1, 3)), 8'($urandom),
                          1'($urandom_range(0, 1)));
            else
                send_word(owbm_pkg::KIND_IDLE, 8'($urandom), pick_level(mode));
        end
    endtask

    task automatic run_op(input owbm_pkg::t_kind op, input logic [7:0] data,
                          input t_level_mode mode, input int noise);
        send_word(op, data, 1'($urandom_range(0, 1)));
        finish_op(mode, noise);
    endtask

    initial begin
        int guard;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ticks while idle, then a byte write on a zero timebase
        send_word(owbm_pkg::KIND_IDLE, 8'hFF, 1'b1);
        send_word(owbm_pkg::KIND_IDLE, 8'h00, 1'b0);
        write_tpu(8'd0);
        run_op(owbm_pkg::KIND_WRITE, 8'hA5, LVL_RAND, 0);

        // bus reset with a device answering, commands while busy, hold-off mid slot
        write_tpu(8'd1);
        send_word(owbm_pkg::KIND_RESET, 8'h00, 1'b1);
        send_word(owbm_pkg::KIND_READ, 8'h3C, 1'b1);
        send_word(owbm_pkg::KIND_RESET, 8'h5A, 1'b0);
        send_word(owbm_pkg::KIND_WRITE, 8'hC3, 1'b1);
        repeat (20) send_word(owbm_pkg::KIND_IDLE, 8'($urandom), 1'b0);
        hold_off();
        finish_op(LVL_LOW, 0);

        // long stretch with no stalls on either side
        quiet = 1'b1;
        run_op(owbm_pkg::KIND_READ, 8'h00, LVL_RAND, 5);
        quiet = 1'b0;

        // slower timebase, the run ends inside the first read slot
        write_tpu(8'd3);
        send_word(owbm_pkg::KIND_READ, 8'($urandom), 1'b1);
        repeat (24) send_word(owbm_pkg::KIND_IDLE, 8'($urandom), pick_level(LVL_RAND));

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (sb.expected_words.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.expected_words.size() != 0) begin
            $display("%0t: result words outstanding, expected 0, actual %0d",
                     $time, sb.expected_words.size());
            sb.errors++;
        end
        $display("run: %0d words in, %0d checked, %0d operations done, %0d commands refused",
                 words_sent, sb.words_checked, sb.ops_done, sb.cmds_rejected);
        $display("run: %0d bus resets, %0d byte writes, %0d byte reads, timebases:%s",
                 sb.cmds_started[owbm_pkg::KIND_RESET], sb.cmds_started[owbm_pkg::KIND_WRITE],
                 sb.cmds_started[owbm_pkg::KIND_READ], tpu_list);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
